### hdl/cll_pkg.sv
// cll_pkg: shared opcodes, error codes and sequencer states of the linked list engine
// no dependencies; imported by cursor_linked_list_engine_unit
package cll_pkg;

  typedef enum logic [4:0] {
    OP_CLEAR      = 5'd0,
    OP_INS_FIRST  = 5'd1,
    OP_INS_LAST   = 5'd2,
    OP_CUR_FIRST  = 5'd3,
    OP_CUR_LAST   = 5'd4,
    OP_RD_FIRST   = 5'd5,
    OP_RD_LAST    = 5'd6,
    OP_DEL_FIRST  = 5'd7,
    OP_DEL_LAST   = 5'd8,
    OP_DEL_AFTER  = 5'd9,
    OP_DEL_BEFORE = 5'd10,
    OP_INS_AFTER  = 5'd11,
    OP_INS_BEFORE = 5'd12,
    OP_RD_CUR     = 5'd13,
    OP_WR_CUR     = 5'd14,
    OP_NEXT       = 5'd15,
    OP_PREV       = 5'd16
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOOK  = 6'b000010,
    ST_LOOK2 = 6'b000100,
    ST_WR_A  = 6'b001000,
    ST_WR_B  = 6'b010000,
    ST_WR_C  = 6'b100000
  } state_e;

endpackage

### hdl/cll_ram.sv
// cll_ram: generic simple dual-port ram with bit write mask and registered read
// no dependencies; used for the node pool of the linked list engine
module cll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [WIDTH-1:0] wmask_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask_i[b]) mem_q[waddr_i][b] <= wdata_i[b];
      end
    end
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cursor_linked_list_engine_unit.sv
// cursor_linked_list_engine_unit: doubly linked list with cursor over a fixed node pool
// depends on cll_pkg (opcodes, error codes, states) and cll_ram (node pool memory)
//
// The block keeps one doubly linked list of VALUE_WIDTH-bit signed values in a pool of
// CAPACITY nodes, with head, tail, cursor and free-list pointers in registers and all
// node contents (value, prev link, next link) in one synchronous ram with a registered
// read. Every accepted beat on the input channel gives exactly one beat on the output
// channel. Items are worked one at a time: clear, cursor moves to an end, next, prev,
// reads and cursor overwrite finish in the lookup step, inserts and deletes at the head
// or tail add link writes, and cursor relative inserts and deletes add a second lookup
// before their link writes. A stalled output register holds the last step of the item
// until it has room. The steps are set by the node ram: one lookup per dependent link and
// one link field written per cycle through its single write port, unless a finishing step
// waits for the output. A finished result sits in the output register, so the next item
// is taken while it waits. No clearing pass is needed after reset or clear: fresh nodes
// come from an allocation counter, freed ones from a free list threaded through next links.
module cursor_linked_list_engine_unit
  import cll_pkg::*;
#(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [4:0]             opcode_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_WIDTH-1:0] read_value_o,
  output logic [1:0]             error_code_o,
  output logic                   cursor_valid_o
);

  // index width holds the null code CAPACITY, address width only real nodes
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // ram entry: {value, prev, next}
  localparam int unsigned EW = VALUE_WIDTH + 2 * IW;
  localparam logic [IW-1:0] NIL    = IW'(CAPACITY);
  localparam logic [EW-1:0] M_NEXT = {{(EW - IW){1'b0}}, {IW{1'b1}}};
  localparam logic [EW-1:0] M_PREV = M_NEXT << IW;
  localparam logic [EW-1:0] M_VAL  = ~(M_NEXT | M_PREV);
  localparam logic [EW-1:0] M_ALL  = '1;

  function automatic logic idx_ok(input logic [IW-1:0] i);
    return i < NIL;
  endfunction

  // sequencer and list registers
  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [IW-1:0]          anc_q, anc_d;     // index read in the first lookup
  logic [IW-1:0]          head_q, head_d;
  logic [IW-1:0]          tail_q, tail_d;
  logic [IW-1:0]          cur_q, cur_d;
  logic [IW-1:0]          free_q, free_d;
  logic [IW-1:0]          unused_q, unused_d;
  logic [IW-1:0]          node_q, node_d;   // node being linked or unlinked
  logic [IW-1:0]          p_q, p_d;         // its left neighbor
  logic [IW-1:0]          x_q, x_d;         // its right neighbor
  logic                   link_q, link_d;   // 1 link in, 0 unlink

  // output register
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] rd_q;
  err_e                   err_q;
  logic                   curv_q;

  // ram ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_wmask, ram_rdata;

  // decoded lookup data
  logic [IW-1:0]          r_next, r_prev;
  logic [VALUE_WIDTH-1:0] r_val;

  // control
  op_e                    in_op;
  logic [IW-1:0]          in_anchor;
  logic [IW-1:0]          del_tgt;
  logic                   take_ok;
  logic [IW-1:0]          take_idx;
  logic                   fin;
  logic                   out_free;
  logic                   adv;
  logic [VALUE_WIDTH-1:0] res_rd;
  err_e                   res_err;

  assign r_next = ram_rdata[IW-1:0];
  assign r_prev = ram_rdata[2*IW-1:IW];
  assign r_val  = ram_rdata[EW-1:2*IW];

  assign in_op = op_e'(opcode_i);

  // a node comes from the free list first, then from the never used part of the pool
  assign take_ok  = idx_ok(free_q) || (unused_q < NIL);
  assign take_idx = idx_ok(free_q) ? free_q : unused_q;

  assign del_tgt = (op_q == OP_DEL_AFTER) ? r_next : r_prev;

  assign out_free = !out_valid_q || !out_stall_i;
  // a finishing step waits for room in the output register, with no side effect
  assign adv      = !fin || out_free;

  // first lookup address by opcode
  always_comb begin
    unique case (in_op)
      OP_RD_FIRST, OP_DEL_FIRST: in_anchor = head_q;
      OP_RD_LAST,  OP_DEL_LAST:  in_anchor = tail_q;
      OP_INS_FIRST, OP_INS_LAST: in_anchor = free_q;
      default:                   in_anchor = cur_q;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    val_d    = val_q;
    anc_d    = anc_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cur_d    = cur_q;
    free_d   = free_q;
    unused_d = unused_q;
    node_d   = node_q;
    p_d      = p_q;
    x_d      = x_q;
    link_d   = link_q;

    ram_re    = 1'b0;
    ram_raddr = anc_q[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = node_q[AW-1:0];
    ram_wdata = '0;
    ram_wmask = '0;

    fin     = 1'b0;
    res_rd  = '0;
    res_err = ERR_OK;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_op;
          val_d     = value_i;
          anc_d     = in_anchor;
          ram_re    = 1'b1;
          ram_raddr = in_anchor[AW-1:0];
          // cursor overwrite needs no lookup, write the value field now
          if (in_op == OP_WR_CUR && idx_ok(cur_q)) begin
            ram_we    = 1'b1;
            ram_waddr = cur_q[AW-1:0];
            ram_wdata = {value_i, {(2 * IW){1'b0}}};
            ram_wmask = M_VAL;
          end
          state_d = ST_LOOK;
        end
      end

      ST_LOOK: begin
        state_d = ST_IDLE;
        fin     = 1'b1;
        unique case (op_q)
          OP_CLEAR: begin
            head_d   = NIL;
            tail_d   = NIL;
            cur_d    = NIL;
            free_d   = NIL;
            unused_d = '0;
          end
          OP_CUR_FIRST: cur_d = head_q;
          OP_CUR_LAST:  cur_d = tail_q;
          OP_RD_FIRST, OP_RD_LAST, OP_RD_CUR: begin
            if (idx_ok(anc_q)) res_rd = r_val;
            else res_err = ERR_EMPTY;
          end
          OP_NEXT: if (idx_ok(anc_q)) cur_d = r_next;
          OP_PREV: if (idx_ok(anc_q)) cur_d = r_prev;
          OP_INS_FIRST, OP_INS_LAST: begin
            if (!take_ok) begin
              res_err = ERR_FULL;
            end else begin
              if (idx_ok(free_q)) free_d = r_next;
              else unused_d = unused_q + IW'(1);
              node_d  = take_idx;
              link_d  = 1'b1;
              p_d     = (op_q == OP_INS_FIRST) ? NIL : tail_q;
              x_d     = (op_q == OP_INS_FIRST) ? head_q : NIL;
              fin     = 1'b0;
              state_d = ST_WR_A;
            end
          end
          OP_INS_AFTER, OP_INS_BEFORE: begin
            // inactive cursor: nothing happens and no node is used
            if (idx_ok(anc_q)) begin
              p_d       = (op_q == OP_INS_AFTER) ? anc_q : r_prev;
              x_d       = (op_q == OP_INS_AFTER) ? r_next : anc_q;
              ram_re    = 1'b1;
              ram_raddr = free_q[AW-1:0];
              fin       = 1'b0;
              state_d   = ST_LOOK2;
            end
          end
          OP_DEL_FIRST, OP_DEL_LAST: begin
            if (idx_ok(anc_q)) begin
              node_d  = anc_q;
              p_d     = r_prev;
              x_d     = r_next;
              link_d  = 1'b0;
              fin     = 1'b0;
              state_d = ST_WR_A;
            end
          end
          OP_DEL_AFTER, OP_DEL_BEFORE: begin
            // cursor on the matching end leaves nothing to delete
            if (idx_ok(anc_q) && idx_ok(del_tgt)) begin
              node_d    = del_tgt;
              ram_re    = 1'b1;
              ram_raddr = del_tgt[AW-1:0];
              fin       = 1'b0;
              state_d   = ST_LOOK2;
            end
          end
          default: ;
        endcase
      end

      ST_LOOK2: begin
        // inserts see the free list head entry, deletes the victim entry
        if (op_q == OP_INS_AFTER || op_q == OP_INS_BEFORE) begin
          if (!take_ok) begin
            res_err = ERR_FULL;
            fin     = 1'b1;
            state_d = ST_IDLE;
          end else begin
            if (idx_ok(free_q)) free_d = r_next;
            else unused_d = unused_q + IW'(1);
            node_d  = take_idx;
            link_d  = 1'b1;
            state_d = ST_WR_A;
          end
        end else begin
          p_d     = r_prev;
          x_d     = r_next;
          link_d  = 1'b0;
          state_d = ST_WR_A;
        end
      end

      ST_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = node_q[AW-1:0];
        if (link_q) begin
          ram_wdata = {val_q, p_q, x_q};
          ram_wmask = M_ALL;
          if (!idx_ok(p_q)) head_d = node_q;
          if (!idx_ok(x_q)) tail_d = node_q;
        end else begin
          // freed node goes on top of the free list
          ram_wdata = {{(EW - IW){1'b0}}, free_q};
          ram_wmask = M_NEXT;
          free_d    = node_q;
          if (!idx_ok(p_q)) head_d = x_q;
          if (!idx_ok(x_q)) tail_d = p_q;
          if (cur_q == node_q) cur_d = NIL;
        end
        if (idx_ok(p_q)) begin
          state_d = ST_WR_B;
        end else if (idx_ok(x_q)) begin
          state_d = ST_WR_C;
        end else begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_WR_B: begin
        // next link of the left neighbor
        ram_we    = 1'b1;
        ram_waddr = p_q[AW-1:0];
        ram_wdata = {{(EW - IW){1'b0}}, (link_q ? node_q : x_q)};
        ram_wmask = M_NEXT;
        if (idx_ok(x_q)) begin
          state_d = ST_WR_C;
        end else begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_WR_C: begin
        // prev link of the right neighbor
        ram_we    = 1'b1;
        ram_waddr = x_q[AW-1:0];
        ram_wdata = {{VALUE_WIDTH{1'b0}}, (link_q ? node_q : p_q), {IW{1'b0}}};
        ram_wmask = M_PREV;
        fin       = 1'b1;
        state_d   = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= NIL;
      tail_q   <= NIL;
      cur_q    <= NIL;
      free_q   <= NIL;
      unused_q <= '0;
    end else if (adv) begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cur_q    <= cur_d;
      free_q   <= free_d;
      unused_q <= unused_d;
    end
  end

  // per-item working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q   <= op_d;
      val_q  <= val_d;
      anc_q  <= anc_d;
      node_q <= node_d;
      p_q    <= p_d;
      x_q    <= x_d;
      link_q <= link_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin && out_free) begin
      rd_q   <= res_rd;
      err_q  <= res_err;
      curv_q <= idx_ok(cur_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = rd_q;
  assign error_code_o   = err_q;
  assign cursor_valid_o = curv_q;

  cll_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we & adv),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .wmask_i (ram_wmask),
    .re_i    (ram_re & adv),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // list is empty at both ends or at neither
  a_ends_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_ok(head_q) == idx_ok(tail_q))
    else $error("head and tail disagree on empty list");

  // an active cursor implies a non-empty list
  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_ok(cur_q) |-> idx_ok(head_q))
    else $error("cursor active on empty list");

  // allocation counter never passes the pool size
  a_unused_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unused_q <= NIL)
    else $error("allocation counter past pool size");

  // a free node must have been handed out before
  a_free_from_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_ok(free_q) |-> (unused_q != '0) && (free_q < unused_q))
    else $error("free list holds a node never allocated");

  // a result is only produced while an item is in flight
  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && out_free) |-> (state_q != ST_IDLE) && (state_d == ST_IDLE))
    else $error("result produced outside an item");

endmodule
